// File: sv/pmfs_pkg.sv
// Package for the particle motion/fade step block: config, command, status types,
// opcode and state enums, and saturation helpers. No dependencies.
package pmfs_pkg;

  localparam int ADDR_W    = 5;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int Q_ONE     = 65536;

  typedef enum logic [2:0] {
    REG_DAMPING  = 3'd0,
    REG_LIFESPAN = 3'd1,
    REG_START    = 3'd2,
    REG_END      = 3'd3,
    REG_SPAWN_X  = 3'd4,
    REG_SPAWN_Y  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_STEP    = 2'd0,
    FUNC_IMPULSE = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef struct packed {
    logic        [17:0] damping;
    logic        [30:0] lifespan;
    logic        [31:0] start_rgba;
    logic        [31:0] end_rgba;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_MUL_VXD, OP_POS_X, OP_MUL_VYD, OP_POS_Y,
    OP_MUL_VXK, OP_VEL_X, OP_MUL_VYK, OP_VEL_Y,
    OP_LIFE, OP_DIV_INIT, OP_DIV, OP_FRAC,
    OP_CH_MUL, OP_CH_WR, OP_IMPULSE, OP_RESTART, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_MUL_VXD, S_POS_X, S_MUL_VYD, S_POS_Y,
    S_MUL_VXK, S_VEL_X, S_MUL_VYK, S_VEL_Y,
    S_LIFE, S_DIV_INIT, S_DIV, S_FRAC,
    S_CH_MUL, S_CH_WR, S_IMPULSE, S_RESTART, S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  div_last;
    logic  ch_last;
    logic  out_free;
  } dp_status_t;

  // clamp a 49-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sh0_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -49'sh0_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp a blended channel to 0..255
  function automatic logic [7:0] sat_chan(input logic signed [42:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 43'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

// File: sv/pmfs_if.sv
// Handshake channel interfaces for the particle step block: input item and result.
// No package dependency.
interface pmfs_item_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [30:0] delta_time;
  logic signed [31:0] impulse_x;
  logic signed [31:0] impulse_y;

  modport source(output valid, func, delta_time, impulse_x, impulse_y, input ready);
  modport sink(input valid, func, delta_time, impulse_x, impulse_y, output ready);
endinterface

interface pmfs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] life_left;
  logic        [7:0]  red;
  logic        [7:0]  green;
  logic        [7:0]  blue;
  logic        [7:0]  alpha;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, life_left,
                 red, green, blue, alpha, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, life_left,
               red, green, blue, alpha, output ready);
endinterface

// File: sv/particle_motion_fade_step.sv
// Particle motion/fade step: a time step runs through dispatch, 8 multiply/update steps, life,
// divide setup, serial divide, fraction, 8 blend steps and emit; impulse and restart run
// dispatch, one update and emit, the unused code dispatch and emit. One word in work at a
// time, taken only in idle; the divide sets the pace of a step, and emit waits for a free
// result register, which lets the next word in while the last result waits. Sync reset, high.
// Depends on pmfs_pkg, pmfs_if, pmfs_regs, pmfs_ctrl, pmfs_dpath.
module particle_motion_fade_step
  import pmfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pmfs_item_if.sink         item,
  pmfs_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       ready;

  // config registers: damping, lifespan, colors, spawn point at 4*index
  pmfs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one opcode per cycle to the datapath
  pmfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (ready),
    .status     (status),
    .cmd        (cmd)
  );

  assign item.ready = ready;

  // datapath: state, multipliers, divider, blend and output word register
  pmfs_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .in_func  (item.func),
    .in_delta (item.delta_time),
    .in_imp_x (item.impulse_x),
    .in_imp_y (item.impulse_y),
    .result   (result)
  );

endmodule

// File: sv/pmfs_regs.sv
// APB-style configuration register file for the particle step block.
// Depends on pmfs_pkg.
module pmfs_regs
  import pmfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.damping    <= 18'd65536;
      cfg.lifespan   <= 31'd65536;
      cfg.start_rgba <= 32'hFFFF_FFFF;
      cfg.end_rgba   <= 32'd0;
      cfg.spawn_x    <= 32'sd0;
      cfg.spawn_y    <= 32'sd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DAMPING:  cfg.damping    <= pwdata[17:0];
        REG_LIFESPAN: cfg.lifespan   <= pwdata[30:0];
        REG_START:    cfg.start_rgba <= pwdata;
        REG_END:      cfg.end_rgba   <= pwdata;
        REG_SPAWN_X:  cfg.spawn_x    <= $signed(pwdata);
        REG_SPAWN_Y:  cfg.spawn_y    <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DAMPING:  prdata = {14'd0, cfg.damping};
      REG_LIFESPAN: prdata = {1'b0, cfg.lifespan};
      REG_START:    prdata = cfg.start_rgba;
      REG_END:      prdata = cfg.end_rgba;
      REG_SPAWN_X:  prdata = cfg.spawn_x;
      REG_SPAWN_Y:  prdata = cfg.spawn_y;
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/pmfs_ctrl.sv
// Sequencer for the particle step block: walks the datapath through one item.
// Depends on pmfs_pkg.
module pmfs_ctrl
  import pmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.func)
          FUNC_STEP:    state_next = S_MUL_VXD;
          FUNC_IMPULSE: state_next = S_IMPULSE;
          FUNC_RESTART: state_next = S_RESTART;
          default:      state_next = S_FINISH;
        endcase
      end
      S_MUL_VXD: begin cmd.op = OP_MUL_VXD; state_next = S_POS_X;  end
      S_POS_X:   begin cmd.op = OP_POS_X;   state_next = S_MUL_VYD; end
      S_MUL_VYD: begin cmd.op = OP_MUL_VYD; state_next = S_POS_Y;  end
      S_POS_Y:   begin cmd.op = OP_POS_Y;   state_next = S_MUL_VXK; end
      S_MUL_VXK: begin cmd.op = OP_MUL_VXK; state_next = S_VEL_X;  end
      S_VEL_X:   begin cmd.op = OP_VEL_X;   state_next = S_MUL_VYK; end
      S_MUL_VYK: begin cmd.op = OP_MUL_VYK; state_next = S_VEL_Y;  end
      S_VEL_Y:   begin cmd.op = OP_VEL_Y;   state_next = S_LIFE;   end
      S_LIFE:    begin cmd.op = OP_LIFE;    state_next = S_DIV_INIT; end
      S_DIV_INIT: begin cmd.op = OP_DIV_INIT; state_next = S_DIV; end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) state_next = S_FRAC;
      end
      S_FRAC:   begin cmd.op = OP_FRAC;   state_next = S_CH_MUL; end
      S_CH_MUL: begin cmd.op = OP_CH_MUL; state_next = S_CH_WR;  end
      S_CH_WR: begin
        cmd.op     = OP_CH_WR;
        state_next = status.ch_last ? S_FINISH : S_CH_MUL;
      end
      S_IMPULSE: begin cmd.op = OP_IMPULSE; state_next = S_FINISH; end
      S_RESTART: begin cmd.op = OP_RESTART; state_next = S_FINISH; end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: sv/pmfs_dpath.sv
// Datapath of the particle step block: particle state, shared multipliers,
// serial divider, color blend and the result register. Depends on pmfs_pkg, pmfs_if.
module pmfs_dpath
  import pmfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic        [1:0]  in_func,
  input  logic        [30:0] in_delta,
  input  logic signed [31:0] in_imp_x,
  input  logic signed [31:0] in_imp_y,
  pmfs_result_if.source      result
);

  // particle state
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, life;
  logic        [31:0] rgba;

  // latched item
  func_t              func;
  logic        [30:0] delta;
  logic signed [31:0] imp_x, imp_y;

  // work registers
  logic signed [63:0] prod;
  logic        [30:0] rem;
  logic        [47:0] dq;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic signed [48:0] frac;
  logic signed [57:0] pb;
  logic        [1:0]  ch;

  // result register
  logic               out_valid;
  logic signed [31:0] o_pos_x, o_pos_y, o_vel_x, o_vel_y, o_life;
  logic        [31:0] o_rgba;

  // motion multiplier: velocity times delta or damping
  logic               sel_x, sel_d;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [47:0] prod_sh;
  logic signed [48:0] prod_ext;

  assign sel_x   = (cmd.op == OP_MUL_VXD) || (cmd.op == OP_MUL_VXK);
  assign sel_d   = (cmd.op == OP_MUL_VXD) || (cmd.op == OP_MUL_VYD);
  assign mul_a   = sel_x ? vel_x : vel_y;
  assign mul_b   = sel_d ? $signed({2'b00, delta}) : $signed({15'd0, cfg.damping});
  assign mul_p   = mul_a * mul_b;
  assign prod_sh = prod[63:16];            // floor shift by 16
  assign prod_ext = {prod_sh[47], prod_sh};

  logic signed [48:0] pos_x_sum, pos_y_sum, life_diff, imp_x_sum, imp_y_sum;
  assign pos_x_sum = {{17{pos_x[31]}}, pos_x} + prod_ext;
  assign pos_y_sum = {{17{pos_y[31]}}, pos_y} + prod_ext;
  assign life_diff = {{17{life[31]}}, life} - $signed({18'd0, delta});
  assign imp_x_sum = {{17{vel_x[31]}}, vel_x} + {{17{imp_x[31]}}, imp_x};
  assign imp_y_sum = {{17{vel_y[31]}}, vel_y} + {{17{imp_y[31]}}, imp_y};

  // restoring divider, one quotient bit per cycle
  logic [30:0] divisor;
  logic [31:0] trial, trial_sub;
  logic        trial_ge;
  logic [31:0] life_mag;
  assign divisor   = (cfg.lifespan == 31'd0) ? 31'd1 : cfg.lifespan;
  assign trial     = {rem, dq[47]};
  assign trial_ge  = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign life_mag  = life[31] ? (~life + 32'd1) : life;

  logic signed [48:0] frac_pos, frac_next;
  assign frac_pos = $signed({1'b0, dq});
  always_comb begin
    if (!neg)                                frac_next = frac_pos;
    else if (dq > 48'(Q_ONE))                frac_next = -49'(Q_ONE);
    else                                     frac_next = -frac_pos;
  end

  // blend: e*1.0 + (s - e)*fraction
  logic        [7:0]  ch_s, ch_e;
  logic signed [8:0]  ch_diff;
  logic signed [57:0] pb_full;
  logic signed [58:0] blend_acc;
  logic        [7:0]  ch_val;
  assign ch_s      = cfg.start_rgba[{ch, 3'b000} +: 8];
  assign ch_e      = cfg.end_rgba[{ch, 3'b000} +: 8];
  assign ch_diff   = $signed({1'b0, ch_s}) - $signed({1'b0, ch_e});
  assign pb_full   = ch_diff * frac;
  assign blend_acc = {pb[57], pb} + $signed({35'd0, ch_e, 16'd0});
  assign ch_val    = sat_chan(blend_acc[58:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= 32'sd0;
      pos_y <= 32'sd0;
      vel_x <= 32'sd0;
      vel_y <= 32'sd0;
      life  <= 32'sd65536;
      rgba  <= 32'd0;
      cnt   <= '0;
      ch    <= 2'd0;
      func  <= FUNC_NOP;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          func  <= func_t'(in_func);
          delta <= in_delta;
          imp_x <= in_imp_x;
          imp_y <= in_imp_y;
        end
        OP_MUL_VXD, OP_MUL_VYD, OP_MUL_VXK, OP_MUL_VYK: prod <= mul_p[63:0];
        OP_POS_X: pos_x <= sat32(pos_x_sum);
        OP_POS_Y: pos_y <= sat32(pos_y_sum);
        OP_VEL_X: vel_x <= sat32(prod_ext);
        OP_VEL_Y: vel_y <= sat32(prod_ext);
        OP_LIFE:  life  <= sat32(life_diff);
        OP_DIV_INIT: begin
          dq  <= {life_mag, 16'd0};
          rem <= 31'd0;
          cnt <= '0;
          neg <= life[31];
        end
        OP_DIV: begin
          rem <= trial_ge ? trial_sub[30:0] : trial[30:0];
          dq  <= {dq[46:0], trial_ge};
          cnt <= cnt + 1'b1;
        end
        OP_FRAC: begin
          frac <= frac_next;
          ch   <= 2'd0;
        end
        OP_CH_MUL: pb <= pb_full;
        OP_CH_WR: begin
          rgba[{ch, 3'b000} +: 8] <= ch_val;
          ch <= ch + 2'd1;
        end
        OP_IMPULSE: begin
          vel_x <= sat32(imp_x_sum);
          vel_y <= sat32(imp_y_sum);
        end
        OP_RESTART: begin
          pos_x <= cfg.spawn_x;
          pos_y <= cfg.spawn_y;
          vel_x <= 32'sd0;
          vel_y <= 32'sd0;
          life  <= $signed({1'b0, cfg.lifespan});
        end
        default: ;
      endcase
    end
  end

  // result word, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      o_pos_x <= pos_x;
      o_pos_y <= pos_y;
      o_vel_x <= vel_x;
      o_vel_y <= vel_y;
      o_life  <= life;
      o_rgba  <= rgba;
    end
  end

  assign result.valid     = out_valid;
  assign result.pos_x     = o_pos_x;
  assign result.pos_y     = o_pos_y;
  assign result.vel_x     = o_vel_x;
  assign result.vel_y     = o_vel_y;
  assign result.life_left = o_life;
  assign result.red       = o_rgba[31:24];
  assign result.green     = o_rgba[23:16];
  assign result.blue      = o_rgba[15:8];
  assign result.alpha     = o_rgba[7:0];

  assign status.func     = func;
  assign status.div_last = (cnt == CNT_W'(DIV_STEPS - 1));
  assign status.ch_last  = (ch == 2'd3);
  assign status.out_free = !out_valid || result.ready;

endmodule

// File: test/tb_top.sv
// Self-checking bench for particle_motion_fade_step: random and directed particle commands,
// checked against an in-bench model of the Euler step, damping and color fade.
// Depends on pmfs_pkg, pmfs_if and the block's RTL.
module tb_top
  import pmfs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;  // idle cycles before the watchdog gives up
  localparam int DRAIN_WAIT  = 80;    // pause before the final check for late results
  localparam int MAX_REPORTS = 10;

  // one input word as the driver sees it
  typedef struct {
    func_t              func;
    logic        [30:0] delta;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
  } particle_cmd_t;

  // particle state, which is also the result word
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] life;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [7:0]  alpha;
  } particle_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  pmfs_item_if   item_ch();
  pmfs_result_if result_ch();

  particle_motion_fade_step dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bench-side copy of the registers and of the particle
  cfg_t            regs_shadow;
  particle_state_t particle;

  particle_cmd_t   pending_words[$];
  particle_state_t predicted_states[$];
  particle_cmd_t   in_flight;
  particle_state_t next_state;

  int queued_cnt   = 0;
  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int error_cnt    = 0;
  int stall_cycles = 0;

  // idle odds in percent, changed per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // weight s by fraction f and e by (1 - f), Q16.16, floor then clamp to a byte
  function automatic logic [7:0] fade_channel(input logic [7:0] s, input logic [7:0] e,
                                              input longint f);
    longint acc;
    acc = longint'(s) * f + longint'(e) * (64'sd65536 - f);
    acc = acc >>> 16;
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  // apply one word to the particle copy and return the state it reports
  function automatic particle_state_t advance_particle(input particle_cmd_t c);
    longint dt;
    longint span;
    longint frac;
    case (c.func)
      FUNC_STEP: begin
        dt   = longint'(c.delta);
        // position moves with the old velocity, then the velocity is damped
        particle.px   = clamp_s32(longint'(particle.px) + ((longint'(particle.vx) * dt) >>> 16));
        particle.py   = clamp_s32(longint'(particle.py) + ((longint'(particle.vy) * dt) >>> 16));
        particle.vx   = clamp_s32((longint'(particle.vx) * longint'(regs_shadow.damping)) >>> 16);
        particle.vy   = clamp_s32((longint'(particle.vy) * longint'(regs_shadow.damping)) >>> 16);
        particle.life = clamp_s32(longint'(particle.life) - dt);
        // a zero lifespan divides as one; the fraction stops at -1.0 but has no top
        span = (regs_shadow.lifespan == 0) ? 64'sd1 : longint'(regs_shadow.lifespan);
        frac = (longint'(particle.life) * 64'sd65536) / span;
        if (frac < -64'sd65536) frac = -64'sd65536;
        particle.red   = fade_channel(regs_shadow.start_rgba[31:24],
                                      regs_shadow.end_rgba[31:24], frac);
        particle.green = fade_channel(regs_shadow.start_rgba[23:16],
                                      regs_shadow.end_rgba[23:16], frac);
        particle.blue  = fade_channel(regs_shadow.start_rgba[15:8],
                                      regs_shadow.end_rgba[15:8], frac);
        particle.alpha = fade_channel(regs_shadow.start_rgba[7:0],
                                      regs_shadow.end_rgba[7:0], frac);
      end
      FUNC_IMPULSE: begin
        particle.vx = clamp_s32(longint'(particle.vx) + longint'(c.push_x));
        particle.vy = clamp_s32(longint'(particle.vy) + longint'(c.push_y));
      end
      FUNC_RESTART: begin
        // color is kept; only a step repaints it
        particle.px   = regs_shadow.spawn_x;
        particle.py   = regs_shadow.spawn_y;
        particle.vx   = '0;
        particle.vy   = '0;
        particle.life = {1'b0, regs_shadow.lifespan};
      end
      default: ;  // unused code: state reported as is
    endcase
    return particle;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word at a time from pending_words; valid holds until taken.
  // The expectation is computed at the edge the word is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        next_state = advance_particle(in_flight);
        predicted_states.push_back(next_state);
        accepted_cnt++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_words.pop_front();
          issued_cnt++;
          item_ch.valid      <= 1'b1;
          item_ch.func       <= in_flight.func;
          item_ch.delta_time <= in_flight.delta;
          item_ch.impulse_x  <= in_flight.push_x;
          item_ch.impulse_y  <= in_flight.push_y;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every accepted result checked in order
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
    if (got !== want) begin
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  particle_state_t oldest;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_states.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: result word with nothing outstanding", $realtime);
        end else begin
          oldest = predicted_states.pop_front();
          compare_field("pos_x", result_ch.pos_x, oldest.px);
          compare_field("pos_y", result_ch.pos_y, oldest.py);
          compare_field("vel_x", result_ch.vel_x, oldest.vx);
          compare_field("vel_y", result_ch.vel_y, oldest.vy);
          compare_field("life_left", result_ch.life_left, oldest.life);
          compare_field("red", {24'd0, result_ch.red}, {24'd0, oldest.red});
          compare_field("green", {24'd0, result_ch.green}, {24'd0, oldest.green});
          compare_field("blue", {24'd0, result_ch.blue}, {24'd0, oldest.blue});
          compare_field("alpha", {24'd0, result_ch.alpha}, {24'd0, oldest.alpha});
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $realtime, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes: setup cycle, access cycle; the register takes the value
  // on the edge that sees psel/penable/pwrite high.
  // ---------------------------------------------------------------------------
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DAMPING:  regs_shadow.damping    = value[17:0];
      REG_LIFESPAN: regs_shadow.lifespan   = value[30:0];
      REG_START:    regs_shadow.start_rgba = value;
      REG_END:      regs_shadow.end_rgba   = value;
      REG_SPAWN_X:  regs_shadow.spawn_x    = value;
      REG_SPAWN_Y:  regs_shadow.spawn_y    = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] damp, input logic [31:0] span,
                              input logic [31:0] rgba0, input logic [31:0] rgba1,
                              input logic [31:0] sx, input logic [31:0] sy);
    reg_write(REG_DAMPING, damp);
    reg_write(REG_LIFESPAN, span);
    reg_write(REG_START, rgba0);
    reg_write(REG_END, rgba1);
    reg_write(REG_SPAWN_X, sx);
    reg_write(REG_SPAWN_Y, sy);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input func_t f, input logic [30:0] dt,
                                     input logic [31:0] ix, input logic [31:0] iy);
    particle_cmd_t c;
    c.func   = f;
    c.delta  = dt;
    c.push_x = ix;
    c.push_y = iy;
    pending_words.push_back(c);
    queued_cnt++;
  endfunction

  // sender holds off until every word is in and every result is out
  task automatic wait_all_done();
    @(negedge clk);
    while (pending_words.size() != 0 || issued_cnt != accepted_cnt ||
           predicted_states.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [31:0] pick_impulse();
    logic [31:0] v;
    if ($urandom_range(99) < 20) return $urandom;
    v = $urandom_range(32'h0010_0000);  // mostly within +-8.0
    return v - 32'h0008_0000;
  endfunction

  // step sizes that walk the life down over a handful of steps
  function automatic logic [30:0] pick_delta();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = (regs_shadow.lifespan == 0) ? 1 : regs_shadow.lifespan;
    if (roll < 10) return 31'($urandom);
    if (roll < 13) return 31'd0;
    if (roll < 15) return 31'h7FFF_FFFF;
    return 31'($urandom_range(span / 6 + 1));
  endfunction

  // restart, up to two pushes, then 4 to 20 words, mostly steps, with pushes
  // and some noise words (unused code, random fields) mixed in
  task automatic queue_life_cycle();
    int n_steps;
    int roll;
    queue_word(FUNC_RESTART, 31'($urandom), $urandom, $urandom);
    repeat ($urandom_range(2))
      queue_word(FUNC_IMPULSE, 31'($urandom), pick_impulse(), pick_impulse());
    n_steps = $urandom_range(4, 20);
    repeat (n_steps) begin
      roll = $urandom_range(99);
      if (roll < 4)
        queue_word(FUNC_NOP, 31'($urandom), $urandom, $urandom);
      else if (roll < 7)
        queue_word(func_t'($urandom_range(3)), 31'($urandom), $urandom, $urandom);
      else if (roll < 15)
        queue_word(FUNC_IMPULSE, 31'($urandom), pick_impulse(), pick_impulse());
      else
        queue_word(FUNC_STEP, pick_delta(), $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int goal;

  initial begin
    item_ch.valid      = 1'b0;
    item_ch.func       = FUNC_NOP;
    item_ch.delta_time = '0;
    item_ch.impulse_x  = '0;
    item_ch.impulse_y  = '0;
    result_ch.ready    = 1'b0;

    regs_shadow.damping    = 18'd65536;
    regs_shadow.lifespan   = 31'd65536;
    regs_shadow.start_rgba = 32'hFFFF_FFFF;
    regs_shadow.end_rgba   = 32'h0000_0000;
    regs_shadow.spawn_x    = '0;
    regs_shadow.spawn_y    = '0;
    particle = '{px: 0, py: 0, vx: 0, vy: 0, life: 32'sd65536,
                 red: 0, green: 0, blue: 0, alpha: 0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    recv_idle_pct = 54;

    // directed, reset registers: zero step shows the start color,
    // velocity saturates both ways, life runs out and the fraction bottoms out
    queue_word(FUNC_STEP, 31'd0, 32'd0, 32'd0);
    queue_word(FUNC_IMPULSE, 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_word(FUNC_IMPULSE, 31'd0, 32'd1, 32'd1);
    queue_word(FUNC_STEP, 31'h0001_0000, 32'd0, 32'd0);
    queue_word(FUNC_STEP, 31'h7FFF_FFFF, 32'd0, 32'd0);
    queue_word(FUNC_IMPULSE, 31'd0, 32'h8000_0000, 32'h8000_0000);
    queue_word(FUNC_IMPULSE, 31'd0, 32'h8000_0000, 32'h8000_0000);
    queue_word(FUNC_NOP, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(FUNC_RESTART, 31'd0, 32'd0, 32'd0);
    queue_word(FUNC_STEP, 31'h0000_8000, 32'd0, 32'd0);
    wait_all_done();

    // zero lifespan, damping beyond 2.0, spawn at the corners of the range
    program_regs(32'h0003_FFFF, 32'd0, 32'h00FF_807F, 32'hFF00_017F,
                 32'h7FFF_FFFF, 32'h8000_0000);
    queue_word(FUNC_RESTART, 31'd0, 32'd0, 32'd0);
    queue_word(FUNC_IMPULSE, 31'd0, 32'h0001_8000, 32'hFFFD_C000);
    queue_word(FUNC_STEP, 31'd1, 32'd0, 32'd0);
    queue_word(FUNC_STEP, 31'h7FFF_FFFF, 32'd0, 32'd0);
    queue_word(FUNC_RESTART, 31'd0, 32'd0, 32'd0);  // color must survive this
    queue_word(FUNC_NOP, 31'd0, 32'd0, 32'd0);
    queue_word(FUNC_STEP, 31'd0, 32'd0, 32'd0);
    wait_all_done();

    // random phases, about 175 words each, with a full drain halfway
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 54;
      end else if (ph < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: program_regs(32'd0, 32'd1, $urandom, $urandom, $urandom, $urandom);
        1: program_regs(32'd131072, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom);
        2: program_regs($urandom_range(32'h3_FFFF), $urandom_range(32'h100, 32'h8_0000),
                        $urandom, $urandom, $urandom, $urandom);
        4: program_regs(32'h0003_FFFF, 32'd0, $urandom, $urandom, $urandom, $urandom);
        default: program_regs($urandom_range(32'hE000, 32'h1_0000),
                              $urandom_range(32'h1_0000, 32'h10_0000),
                              $urandom, $urandom, $urandom, $urandom);
      endcase
      repeat (2) begin
        goal = queued_cnt + 88;
        while (queued_cnt < goal) queue_life_cycle();
        wait_all_done();
      end
    end

    // late or extra results would show up in the monitor during this pause
    repeat (DRAIN_WAIT) @(posedge clk);
    if (predicted_states.size() != 0) error_cnt++;
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pmfs_pkg.sv
sv/pmfs_if.sv
sv/pmfs_regs.sv
sv/pmfs_ctrl.sv
sv/pmfs_dpath.sv
sv/particle_motion_fade_step.sv
test/tb_top.sv
